// ----- hw/rtl/reversible_deque_macros.svh -----
// Assertion helpers, clocked on aclk and quiet while aresetn is low.
`ifndef REVERSIBLE_DEQUE_MACROS_SVH
`define REVERSIBLE_DEQUE_MACROS_SVH

// Same-cycle implication.
`define RD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define RD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/rd_pkg.sv -----
package rd_pkg;

    localparam int DEPTH       = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int AW          = $clog2(DEPTH);
    localparam int CW          = $clog2(DEPTH + 1);

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_BACK   = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_REVERSE    = 3'd4;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_VALID = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_POP_WAIT
    } rd_state_t;

    // one access per cycle to the entry store
    typedef struct packed {
        logic                   we;
        logic                   re;
        logic [AW-1:0]          addr;
        logic [VALUE_WIDTH-1:0] wdata;
    } rd_mem_req_t;

    function automatic logic [VALUE_WIDTH-1:0] to_store(input logic [31:0] v);
        logic [63:0] tmp;
        tmp = 64'(v);
        return tmp[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] to_out(input logic [VALUE_WIDTH-1:0] v);
        logic [63:0] tmp;
        tmp = 64'(v);
        return tmp[31:0];
    endfunction

endpackage

// ----- hw/rtl/rd_ram.sv -----
module rd_ram #(
    parameter int DEPTH_P = 1024,
    parameter int WIDTH_P = 32
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic                       re,
    input  logic [$clog2(DEPTH_P)-1:0] addr,
    input  logic [WIDTH_P-1:0]         wdata,
    output logic [WIDTH_P-1:0]         rdata
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];
    logic [WIDTH_P-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/rd_ctrl.sv -----
module rd_ctrl import rd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [2:0]             op,
    input  logic [31:0]            value,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [1:0]             status,
    output logic [31:0]            popped_value,
    output rd_mem_req_t            mem_req,
    input  logic [VALUE_WIDTH-1:0] mem_rdata
);

    localparam logic [AW+1:0] DEPTH_W = (AW + 2)'(DEPTH);
    localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

    rd_state_t     state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          rev_reg, rev_next;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_status_reg, out_status_next;
    logic [31:0]   out_data_reg, out_data_next;

    logic          accept;
    logic          phys_front;
    logic          is_pop;
    logic [AW-1:0] head_inc, head_dec;
    logic [AW+1:0] tail_sum, last_sum;
    logic [AW-1:0] tail_idx, last_idx;

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign is_pop   = (op == OP_POP_BACK) || (op == OP_POP_FRONT);
    assign phys_front = ((op == OP_PUSH_FRONT) || (op == OP_POP_FRONT)) != rev_reg;

    assign head_inc = (head_reg == LAST_A) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_A : head_reg - 1'b1;

    // slot after the physical back, and the physical back itself
    assign tail_sum = (AW + 2)'(head_reg) + (AW + 2)'(count_reg);
    assign last_sum = tail_sum - 1'b1;
    always_comb begin
        logic [AW+1:0] t, l;
        t = (tail_sum >= DEPTH_W) ? tail_sum - DEPTH_W : tail_sum;
        l = (last_sum >= DEPTH_W) ? last_sum - DEPTH_W : last_sum;
        tail_idx = t[AW-1:0];
        last_idx = l[AW-1:0];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && is_pop && (count_reg != '0)) begin
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT: state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        head_next       = head_reg;
        count_next      = count_reg;
        rev_next        = rev_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        mem_req         = '0;
        mem_req.wdata   = to_store(value);

        if (accept) begin
            out_valid_next  = 1'b1;
            out_status_next = STAT_DONE;
            out_data_next   = '0;
            case (op)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (count_reg == FULL_C) begin
                        out_status_next = STAT_FULL;
                    end else begin
                        mem_req.we = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (phys_front) begin
                            head_next    = head_dec;
                            mem_req.addr = head_dec;
                        end else begin
                            mem_req.addr = tail_idx;
                        end
                    end
                end
                OP_POP_BACK, OP_POP_FRONT: begin
                    if (count_reg == '0) begin
                        out_status_next = STAT_EMPTY;
                    end else begin
                        // result lands when the store returns the data
                        out_valid_next = 1'b0;
                        mem_req.re     = 1'b1;
                        count_next     = count_reg - 1'b1;
                        if (phys_front) begin
                            mem_req.addr = head_reg;
                            head_next    = head_inc;
                        end else begin
                            mem_req.addr = last_idx;
                        end
                    end
                end
                OP_REVERSE: rev_next = !rev_reg;
                default: ;
            endcase
        end

        if (state_reg == ST_POP_WAIT) begin
            out_valid_next  = 1'b1;
            out_status_next = STAT_VALID;
            out_data_next   = to_out(mem_rdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            out_valid_reg <= out_valid_next;
        end
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
    end

    assign m_tvalid     = out_valid_reg;
    assign status       = out_status_reg;
    assign popped_value = out_data_reg;

endmodule

// ----- hw/rtl/reversible_deque.sv -----
// Double-ended queue of signed 32-bit values with a one-step reverse. Each
// input transaction carries an op in s_tuser (push front, push back, pop back,
// pop front, reverse) and the value to push in s_tdata; each gives exactly one
// result transaction with a status in m_tuser (done, popped value valid, queue
// empty, full and dropped) and the popped value in m_tdata (zero unless a pop
// returned data). Entries live in a 1024-entry synchronous RAM addressed as a
// ring from a head pointer and an entry count; a reverse flag swaps which
// physical end each logical end names. Pushes, reverse, unused op codes and
// pops on an empty queue need no wait state; a pop that returns data
// waits for the registered read data of the entry RAM. The result sits in an
// output register, so a new transaction is taken in the same cycle the
// previous result is taken. No clearing pass after reset: entries are only
// ever read after they have been written.
module reversible_deque import rd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [2:0]  s_tuser,   // [2:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] popped_value
    output logic [1:0]  m_tuser    // [1:0] status
);

    rd_mem_req_t            mem_req;
    logic [VALUE_WIDTH-1:0] mem_rdata;

    // pointers, count, reverse flag, sequencing and the result register
    rd_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .op           (s_tuser),
        .value        (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .status       (m_tuser),
        .popped_value (m_tdata),
        .mem_req      (mem_req),
        .mem_rdata    (mem_rdata)
    );

    // entry store: one access per cycle, reads and writes never share a cycle
    rd_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (VALUE_WIDTH)
    ) u_ram (
        .clk   (aclk),
        .we    (mem_req.we),
        .re    (mem_req.re),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

endmodule

// ----- hw/rtl/rd_checker.sv -----
`include "reversible_deque_macros.svh"

module rd_checker import rd_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    logic s_acc;
    logic m_stall;
    logic rev_acc;
    logic push_acc;
    logic push_ok;

    assign s_acc    = s_tvalid && s_tready;
    assign m_stall  = m_tvalid && !m_tready;
    assign rev_acc  = s_acc && (s_tuser == OP_REVERSE);
    assign push_acc = s_acc && ((s_tuser == OP_PUSH_FRONT) || (s_tuser == OP_PUSH_BACK));
    assign push_ok  = (m_tuser == STAT_DONE) || (m_tuser == STAT_FULL);

    // stalled result holds
    `RD_ASSERT_NEXT(a_out_hold, m_stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // data only with a valid pop
    `RD_ASSERT_IMPL(a_data_zero, m_tvalid && (m_tuser != STAT_VALID), m_tdata == '0)

    // reverse answers next cycle with done
    `RD_ASSERT_NEXT(a_rev_done, rev_acc, m_tvalid && (m_tuser == STAT_DONE))

    // push answers next cycle with done or full
    `RD_ASSERT_NEXT(a_push_resp, push_acc, m_tvalid && push_ok)

endmodule

bind reversible_deque rd_checker u_rd_checker (.*);
